// ===== rtl/core/phc_pkg.sv =====
package phc_pkg;

    // Widths of the body stream and of the checksum
    localparam int WORD_W     = 16;
    localparam int NBYTE_W    = 2;
    localparam int ADDR_HALF_W = 64;
    localparam int PROTO_W    = 8;

    // Widest body length counter; the length enters the sum as two words
    localparam int LEN_EXT_W       = 32;
    localparam int LENGTH_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IS_IPV6   = 3'd0;
    localparam t_cfg_idx CFG_PROTOCOL  = 3'd1;
    localparam t_cfg_idx CFG_SRC_HIGH  = 3'd2;
    localparam t_cfg_idx CFG_SRC_LOW   = 3'd3;
    localparam t_cfg_idx CFG_DST_HIGH  = 3'd4;
    localparam t_cfg_idx CFG_DST_LOW   = 3'd5;

    // Address family code (AF_INET selects the IPv4 pseudo-header)
    localparam logic FAM_INET = 1'b0;

    localparam logic [WORD_W-1:0] WORD_MASK = 16'hFFFF;
    localparam logic [WORD_W-1:0] HIGH_BYTE_MASK = 16'hFF00;

    // Byte counts of one body word
    localparam logic [NBYTE_W-1:0] NB_NONE = 2'd0;
    localparam logic [NBYTE_W-1:0] NB_ONE  = 2'd1;
    localparam logic [NBYTE_W-1:0] NB_TWO  = 2'd2;

    // Plain sum of the four 16-bit words of a 64-bit value
    localparam int QUAD_SUM_W = WORD_W + 2;

    function automatic logic [QUAD_SUM_W-1:0] quad_sum(input logic [ADDR_HALF_W-1:0] v);
        quad_sum = QUAD_SUM_W'(v[63:48]) + QUAD_SUM_W'(v[47:32])
                 + QUAD_SUM_W'(v[31:16]) + QUAD_SUM_W'(v[15:0]);
    endfunction

endpackage

// ===== rtl/core/phc_ifs.sv =====
// Body word channel
interface phc_in_if;
    logic                               valid;
    logic                               ready;
    logic [phc_pkg::WORD_W-1:0]         data_word;
    logic [phc_pkg::NBYTE_W-1:0]        byte_valid;
    logic                               last;

    modport source (output valid, data_word, byte_valid, last, input ready);
    modport sink   (input valid, data_word, byte_valid, last, output ready);
endinterface

// Checksum result channel
interface phc_out_if;
    logic                               valid;
    logic                               ready;
    logic [phc_pkg::WORD_W-1:0]         checksum;

    modport source (output valid, checksum, input ready);
    modport sink   (input valid, checksum, output ready);
endinterface

// Register write channel
interface phc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [phc_pkg::CFG_IDX_W-1:0]      index;
    logic [phc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/phc_cfg_regs.sv =====
module phc_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    phc_cfg_if.sink                     i_cfg,
    output logic [phc_pkg::WORD_W-1:0]  o_hdr_sum
);

    localparam int PART_W = phc_pkg::QUAD_SUM_W;
    localparam int HSUM_W = PART_W + 3;

    logic                                   r_is_ipv6;
    logic [phc_pkg::PROTO_W-1:0]            r_proto;
    logic [phc_pkg::ADDR_HALF_W-1:0]        r_src_hi;
    logic [phc_pkg::ADDR_HALF_W-1:0]        r_src_lo;
    logic [phc_pkg::ADDR_HALF_W-1:0]        r_dst_hi;
    logic [phc_pkg::ADDR_HALF_W-1:0]        r_dst_lo;

    logic [PART_W-1:0]                      r_part [4];
    logic [PART_W-1:0]                      n_part [4];
    logic [phc_pkg::PROTO_W-1:0]            r_part_proto;
    logic [phc_pkg::WORD_W-1:0]             r_hdr;
    logic [phc_pkg::WORD_W-1:0]             n_hdr;

    logic [HSUM_W-1:0]                      hsum;
    logic [phc_pkg::WORD_W:0]               hfold;

    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_ipv6 <= phc_pkg::FAM_INET;
            r_proto   <= '0;
            r_src_hi  <= '0;
            r_src_lo  <= '0;
            r_dst_hi  <= '0;
            r_dst_lo  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                phc_pkg::CFG_IS_IPV6:  r_is_ipv6 <= i_cfg.data[0];
                phc_pkg::CFG_PROTOCOL: r_proto   <= i_cfg.data[phc_pkg::PROTO_W-1:0];
                phc_pkg::CFG_SRC_HIGH: r_src_hi  <= i_cfg.data;
                phc_pkg::CFG_SRC_LOW:  r_src_lo  <= i_cfg.data;
                phc_pkg::CFG_DST_HIGH: r_dst_hi  <= i_cfg.data;
                phc_pkg::CFG_DST_LOW:  r_dst_lo  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // First stage: per-register word sums; IPv4 uses only the low 32 bits
    always_comb begin
        if (r_is_ipv6 == phc_pkg::FAM_INET) begin
            n_part[0] = '0;
            n_part[1] = PART_W'(r_src_lo[31:16]) + PART_W'(r_src_lo[15:0]);
            n_part[2] = '0;
            n_part[3] = PART_W'(r_dst_lo[31:16]) + PART_W'(r_dst_lo[15:0]);
        end else begin
            n_part[0] = phc_pkg::quad_sum(r_src_hi);
            n_part[1] = phc_pkg::quad_sum(r_src_lo);
            n_part[2] = phc_pkg::quad_sum(r_dst_hi);
            n_part[3] = phc_pkg::quad_sum(r_dst_lo);
        end
    end

    // Second stage: add partials and protocol, fold end-around carries
    always_comb begin
        hsum  = HSUM_W'(r_part[0]) + HSUM_W'(r_part[1]) + HSUM_W'(r_part[2])
              + HSUM_W'(r_part[3]) + HSUM_W'(r_part_proto);
        hfold = (phc_pkg::WORD_W+1)'(hsum[phc_pkg::WORD_W-1:0])
              + (phc_pkg::WORD_W+1)'(hsum[HSUM_W-1:phc_pkg::WORD_W]);
        n_hdr = hfold[phc_pkg::WORD_W-1:0] + phc_pkg::WORD_W'(hfold[phc_pkg::WORD_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part[0]    <= '0;
            r_part[1]    <= '0;
            r_part[2]    <= '0;
            r_part[3]    <= '0;
            r_part_proto <= '0;
            r_hdr        <= '0;
        end else begin
            r_part       <= n_part;
            r_part_proto <= r_proto;
            r_hdr        <= n_hdr;
        end
    end

    assign o_hdr_sum = r_hdr;

endmodule

// ===== rtl/core/phc_body_acc.sv =====
module phc_body_acc #(
    parameter int LENGTH_BITS = phc_pkg::LENGTH_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [phc_pkg::WORD_W-1:0]  i_hdr_sum,
    phc_in_if.sink                      i_in,
    phc_out_if.source                   o_res
);

    localparam int W  = phc_pkg::WORD_W;
    localparam int FW = W + 2;

    // Input register
    logic                   r_in_valid;
    logic [W-1:0]           r_in_word;
    logic [phc_pkg::NBYTE_W-1:0] r_in_nb;
    logic                   r_in_last;

    // Running state
    logic [W-1:0]           r_sum;
    logic [LENGTH_BITS-1:0] r_len;

    // Snapshot of a finished packet
    logic                   r_fin_valid;
    logic [W-1:0]           r_fin_sum;
    logic [LENGTH_BITS-1:0] r_fin_len;

    // Output register
    logic                   r_out_valid;
    logic [W-1:0]           r_out_csum;

    logic                   out_free;
    logic                   fin_adv;
    logic                   fin_free;
    logic                   in_adv;
    logic                   in_take;

    logic [W-1:0]           in_word_m;
    logic [phc_pkg::NBYTE_W-1:0] in_nb_s;

    logic [W:0]             acc_s;
    logic [W-1:0]           n_sum;
    logic [LENGTH_BITS:0]   len_s;
    logic [LENGTH_BITS-1:0] n_len;

    logic [phc_pkg::LEN_EXT_W-1:0] len_ext;
    logic [FW-1:0]          fsum;
    logic [W:0]             ffold;
    logic [W-1:0]           n_csum;

    // Handshake: non-last words never wait on the result side
    assign out_free    = !r_out_valid || o_res.ready;
    assign fin_adv     = r_fin_valid && out_free;
    assign fin_free    = !r_fin_valid || fin_adv;
    assign in_adv      = r_in_valid && (!r_in_last || fin_free);
    assign i_in.ready  = !r_in_valid || in_adv;
    assign in_take     = i_in.valid && i_in.ready;

    // Byte count clamp and byte masking at entry
    always_comb begin
        case (i_in.byte_valid)
            phc_pkg::NB_NONE: begin
                in_nb_s   = phc_pkg::NB_NONE;
                in_word_m = '0;
            end
            phc_pkg::NB_ONE: begin
                in_nb_s   = phc_pkg::NB_ONE;
                in_word_m = i_in.data_word & phc_pkg::HIGH_BYTE_MASK;
            end
            default: begin
                in_nb_s   = phc_pkg::NB_TWO;
                in_word_m = i_in.data_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= in_word_m;
            r_in_nb   <= in_nb_s;
            r_in_last <= i_in.last;
        end
    end

    // End-around add and saturating byte count
    always_comb begin
        acc_s = (W+1)'(r_sum) + (W+1)'(r_in_word);
        n_sum = acc_s[W-1:0] + W'(acc_s[W]);
        len_s = (LENGTH_BITS+1)'(r_len) + (LENGTH_BITS+1)'(r_in_nb);
        n_len = len_s[LENGTH_BITS] ? '1 : len_s[LENGTH_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_len <= '0;
        end else if (in_adv) begin
            if (r_in_last) begin
                r_sum <= '0;
                r_len <= '0;
            end else begin
                r_sum <= n_sum;
                r_len <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (in_adv && r_in_last) begin
            r_fin_valid <= 1'b1;
        end else if (fin_adv) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && r_in_last) begin
            r_fin_sum <= n_sum;
            r_fin_len <= n_len;
        end
    end

    // Add pseudo-header and length words, fold, complement
    always_comb begin
        len_ext = phc_pkg::LEN_EXT_W'(r_fin_len);
        fsum    = FW'(r_fin_sum) + FW'(i_hdr_sum)
                + FW'(len_ext[31:16]) + FW'(len_ext[15:0]);
        ffold   = (W+1)'(fsum[W-1:0]) + (W+1)'(fsum[FW-1:W]);
        n_csum  = ~(ffold[W-1:0] + W'(ffold[W]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_adv) begin
            r_out_csum <= n_csum;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.checksum = r_out_csum;

endmodule

// ===== rtl/core/pseudo_header_checksum_core.sv =====
// TCP/UDP checksum over an IPv4 or IPv6 pseudo-header and a streamed body.
// Body words (big-endian, first byte in bits 15:8) are taken one per clock with
// no gaps needed, except that a last word waits while a held result fills the
// snapshot and output registers; the body sum is a single 16-bit end-around add
// per word, which sets that rate. A word with one valid byte counts as its high
// byte; a byte count of three counts as two. The word flagged last closes the
// packet: its checksum passes the snapshot and output registers, while the next
// packet's words keep flowing in. The byte length saturates at 2^LENGTH_BITS-1.
// The register port is always ready; the pseudo-header sum trails a write through
// registered stages, so write registers only while no packet is in flight.
module pseudo_header_checksum_core #(
    parameter int LENGTH_BITS = phc_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phc_in_if.sink      i_in,
    phc_out_if.source   o_res,
    phc_cfg_if.sink     i_cfg
);

    logic [phc_pkg::WORD_W-1:0] hdr_sum;

    // Configuration registers and pseudo-header sum
    phc_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_hdr_sum (hdr_sum)
    );

    // Body accumulator and result register
    phc_body_acc #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_body (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hdr_sum (hdr_sum),
        .i_in      (i_in),
        .o_res     (o_res)
    );

endmodule
